>>> hdl/v3n_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3n_pkg
// Shared types and constants for the vector normalizer.
// ----------------------------------------------------------------------------
package v3n_pkg;

    localparam int unsigned NUM_COMP = 3;

    typedef struct packed {
        logic [NUM_COMP-1:0] neg;
        logic                zero;
    } t_flags;

endpackage

>>> hdl/v3n_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3n_in_if / v3n_out_if
// Valid/ready channels carrying the input vector and the unit vector words.
// ----------------------------------------------------------------------------
interface v3n_in_if #(
    parameter int IN_WIDTH = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] vec_x;
    logic signed [IN_WIDTH-1:0] vec_y;
    logic signed [IN_WIDTH-1:0] vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface v3n_out_if #(
    parameter int OUT_WIDTH = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] unit_x;
    logic signed [OUT_WIDTH-1:0] unit_y;
    logic signed [OUT_WIDTH-1:0] unit_z;
    logic                        zero_length;

    modport source (output valid, output unit_x, output unit_y, output unit_z,
                    output zero_length, input ready);
    modport sink   (input valid, input unit_x, input unit_y, input unit_z,
                    input zero_length, output ready);
endinterface

>>> hdl/v3n_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3n_isqrt
// Pipelined digit-by-digit square root of sum * 4^F, one root bit a stage.
// ----------------------------------------------------------------------------
module v3n_isqrt #(
    parameter int IW     = 16,
    parameter int F      = 14,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic [IW+F:0]         i_adv,
    input  logic [2*IW+1:0]       i_sum,
    input  logic [SIDE_W-1:0]     i_side,
    output logic [IW+F:0]         o_root,
    output logic [SIDE_W-1:0]     o_side
);
    localparam int LW = IW + 1 + F;
    localparam int SW = 2 * IW + 2;
    localparam int RW = LW + 3;

    logic [RW-1:0]     r_rem  [LW];
    logic [LW-1:0]     r_root [LW];
    logic [SW-1:0]     r_sum  [LW];
    logic [SIDE_W-1:0] r_side [LW];

    for (genvar i = 0; i < LW; i++) begin : g_stage
        localparam int J = LW - 1 - i;
        logic [RW-1:0]     rem_in;
        logic [LW-1:0]     root_in;
        logic [SW-1:0]     sum_in;
        logic [SIDE_W-1:0] side_in;
        logic [1:0]        pair;
        logic [RW-1:0]     cur;
        logic [RW-1:0]     trial;
        logic [RW-1:0]     n_rem;
        logic [LW-1:0]     n_root;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign sum_in  = i_sum;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[i-1];
            assign root_in = r_root[i-1];
            assign sum_in  = r_sum[i-1];
            assign side_in = r_side[i-1];
        end

        if (J >= F) begin : g_data
            assign pair = sum_in[2*(J-F)+1 -: 2];
        end else begin : g_frac
            assign pair = 2'b00;
        end

        assign cur   = {rem_in[RW-3:0], pair};
        assign trial = {{(RW-LW-2){1'b0}}, root_in, 2'b01};

        always_comb begin
            if (cur >= trial) begin
                n_rem  = cur - trial;
                n_root = {root_in[LW-2:0], 1'b1};
            end else begin
                n_rem  = cur;
                n_root = {root_in[LW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv[i]) begin
                r_rem[i]  <= n_rem;
                r_root[i] <= n_root;
                r_sum[i]  <= sum_in;
                r_side[i] <= side_in;
            end
        end
    end

    assign o_root = r_root[LW-1];
    assign o_side = r_side[LW-1];

endmodule

>>> hdl/v3n_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3n_div
// Pipelined restoring divider: mag * 4^F / len for each component,
// one quotient bit a stage.
// ----------------------------------------------------------------------------
module v3n_div #(
    parameter int IW = 16,
    parameter int F  = 14
) (
    input  logic                                      i_clk,
    input  logic [F:0]                                i_adv,
    input  logic [IW+F:0]                             i_len,
    input  logic [v3n_pkg::NUM_COMP-1:0][IW-1:0]      i_mag,
    input  v3n_pkg::t_flags                           i_flags,
    output logic [v3n_pkg::NUM_COMP-1:0][F:0]         o_quo,
    output v3n_pkg::t_flags                           o_flags
);
    localparam int LW = IW + 1 + F;
    localparam int DW = LW + 1;
    localparam int QW = F + 1;
    localparam int NC = v3n_pkg::NUM_COMP;

    logic [NC-1:0][DW-1:0] r_rem   [QW];
    logic [NC-1:0][QW-1:0] r_quo   [QW];
    logic [LW-1:0]         r_len   [QW];
    v3n_pkg::t_flags       r_flags [QW];

    for (genvar d = 0; d < QW; d++) begin : g_stage
        logic [NC-1:0][DW-1:0] rem_in;
        logic [NC-1:0][QW-1:0] quo_in;
        logic [LW-1:0]         len_in;
        v3n_pkg::t_flags       flags_in;
        logic [NC-1:0][DW-1:0] n_rem;
        logic [NC-1:0][QW-1:0] n_quo;

        if (d == 0) begin : g_first
            for (genvar c = 0; c < NC; c++) begin : g_init
                assign rem_in[c] = {{(DW-IW-F+1){1'b0}}, i_mag[c], {(F-1){1'b0}}};
            end
            assign quo_in   = '0;
            assign len_in   = i_len;
            assign flags_in = i_flags;
        end else begin : g_next
            assign rem_in   = r_rem[d-1];
            assign quo_in   = r_quo[d-1];
            assign len_in   = r_len[d-1];
            assign flags_in = r_flags[d-1];
        end

        always_comb begin
            logic [DW-1:0] t;
            for (int c = 0; c < NC; c++) begin
                t = {rem_in[c][DW-2:0], 1'b0};
                if (t >= {1'b0, len_in}) begin
                    n_rem[c] = t - {1'b0, len_in};
                    n_quo[c] = {quo_in[c][QW-2:0], 1'b1};
                end else begin
                    n_rem[c] = t;
                    n_quo[c] = {quo_in[c][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv[d]) begin
                r_rem[d]   <= n_rem;
                r_quo[d]   <= n_quo;
                r_len[d]   <= len_in;
                r_flags[d] <= flags_in;
            end
        end
    end

    assign o_quo   = r_quo[QW-1];
    assign o_flags = r_flags[QW-1];

endmodule

>>> hdl/vector3_normalize_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize_top
// Scales a signed 3-vector to unit length in Q1.OUT_FRAC_BITS.
// ----------------------------------------------------------------------------
// Takes one word per cycle and returns one word per cycle while the output
// is ready. Three stages form magnitudes, squares and their sum, the square
// root spends one stage per root bit and the three parallel dividers one
// stage per quotient bit, then a final stage clamps and restores signs.
// Every stage stalls only when it is full and the one after it is held, so
// bubbles are squeezed out and input is taken while a result waits.
// A zero vector returns zeros with zero_length set.
module vector3_normalize_top #(
    parameter int IN_WIDTH      = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    v3n_in_if.sink    i_in,
    v3n_out_if.source o_out
);
    localparam int IW     = IN_WIDTH;
    localparam int F      = OUT_FRAC_BITS;
    localparam int OW     = F + 2;
    localparam int LW     = IW + 1 + F;
    localparam int SW     = 2 * IW + 2;
    localparam int QW     = F + 1;
    localparam int NC     = v3n_pkg::NUM_COMP;
    localparam int SIDE_W = NC * IW + $bits(v3n_pkg::t_flags);
    localparam int S_SQRT = 3;
    localparam int S_DIV  = S_SQRT + LW;
    localparam int NS     = S_DIV + QW + 1;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] adv;

    logic [NC-1:0][IW-1:0]   r_mag0, r_mag1, r_mag2;
    v3n_pkg::t_flags         r_flags0, r_flags1, r_flags2;
    logic [NC-1:0][2*IW-1:0] r_sq;
    logic [SW-1:0]           r_sum;
    logic [NC-1:0][OW-1:0]   r_unit;
    logic                    r_zero;

    logic [NC-1:0][IW-1:0]   n_mag;
    v3n_pkg::t_flags         n_flags;
    logic [IW-1:0]           comp_in [NC];

    logic [SIDE_W-1:0]       sq_side;
    logic [LW-1:0]           root;
    logic [NC-1:0][IW-1:0]   div_mag;
    v3n_pkg::t_flags         div_flags;
    logic [NC-1:0][QW-1:0]   quo;
    v3n_pkg::t_flags         quo_flags;
    logic [NC-1:0][OW-1:0]   n_unit;

    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || o_out.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign i_in.ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_in.valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign comp_in[0] = i_in.vec_x;
    assign comp_in[1] = i_in.vec_y;
    assign comp_in[2] = i_in.vec_z;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            n_flags.neg[c] = comp_in[c][IW-1];
            n_mag[c]       = comp_in[c][IW-1] ? (~comp_in[c] + 1'b1) : comp_in[c];
        end
        n_flags.zero = (comp_in[0] == '0) && (comp_in[1] == '0) && (comp_in[2] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_mag0   <= n_mag;
            r_flags0 <= n_flags;
        end
        if (adv[1]) begin
            for (int c = 0; c < NC; c++) begin
                r_sq[c] <= r_mag0[c] * r_mag0[c];
            end
            r_mag1   <= r_mag0;
            r_flags1 <= r_flags0;
        end
        if (adv[2]) begin
            r_sum    <= {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
            r_mag2   <= r_mag1;
            r_flags2 <= r_flags1;
        end
    end

    v3n_isqrt #(
        .IW     (IW),
        .F      (F),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_adv  (adv[S_SQRT +: LW]),
        .i_sum  (r_sum),
        .i_side ({r_mag2, r_flags2}),
        .o_root (root),
        .o_side (sq_side)
    );

    assign {div_mag, div_flags} = sq_side;

    v3n_div #(
        .IW (IW),
        .F  (F)
    ) u_div (
        .i_clk   (i_clk),
        .i_adv   (adv[S_DIV +: QW]),
        .i_len   (root),
        .i_mag   (div_mag),
        .i_flags (div_flags),
        .o_quo   (quo),
        .o_flags (quo_flags)
    );

    always_comb begin
        logic [OW-1:0] q;
        for (int c = 0; c < NC; c++) begin
            q = {1'b0, quo[c]};
            if (q > (OW'(1) << F)) begin
                q = OW'(1) << F;
            end
            if (quo_flags.zero) begin
                n_unit[c] = '0;
            end else if (quo_flags.neg[c]) begin
                n_unit[c] = ~q + 1'b1;
            end else begin
                n_unit[c] = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[NS-1]) begin
            r_unit <= n_unit;
            r_zero <= quo_flags.zero;
        end
    end

    assign o_out.valid       = r_vld[NS-1];
    assign o_out.unit_x      = r_unit[0];
    assign o_out.unit_y      = r_unit[1];
    assign o_out.unit_z      = r_unit[2];
    assign o_out.zero_length = r_zero;

`ifndef NO_ASSERTIONS
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.zero_length |->
            o_out.unit_x == '0 && o_out.unit_y == '0 && o_out.unit_z == '0)
        else $error("zero vector gave nonzero output");

    a_range_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> $signed(o_out.unit_x) <= $signed(OW'(1) << F) &&
                        $signed(o_out.unit_x) >= -$signed(OW'(1) << F))
        else $error("unit_x out of range");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (&r_vld) && !o_out.ready)
        else $error("input held while pipeline has a bubble");
`endif

endmodule
